@@ src/clasm_pkg.sv @@
`default_nettype none

package clasm_pkg;

    // Depth of the line store and the widths that follow from it.
    localparam int LINE_DEPTH = 64;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int SIZE_W     = IDX_W + 1;
    localparam int CHAR_W     = 8;
    localparam int STAT_W     = 2;

    // Control characters with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_INCOMPLETE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DONE       = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL       = 2'd2;

    // Class of a received character.
    typedef enum logic [2:0] {
        CK_EOL   = 3'd0,
        CK_BS    = 3'd1,
        CK_QUOTE = 3'd2,
        CK_SEMI  = 3'd3,
        CK_OTHER = 3'd4
    } char_kind_t;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        char_kind_t        kind;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_BSCHK = 3'b010,
        S_DRAIN = 3'b100
    } back_state_t;

    function automatic char_kind_t classify(input logic [CHAR_W-1:0] ch);
        char_kind_t kind;
        priority if (ch == CH_CR || ch == CH_LF) kind = CK_EOL;
        else if (ch == CH_BS)                    kind = CK_BS;
        else if (ch == CH_QUOTE)                 kind = CK_QUOTE;
        else if (ch == CH_SEMI)                  kind = CK_SEMI;
        else                                     kind = CK_OTHER;
        return kind;
    endfunction

endpackage

`default_nettype wire

@@ src/clasm_front.sv @@
`default_nettype none

module clasm_front
    import clasm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CHAR_W-1:0] in_char,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  wire logic              cmd_pop
);

    // Two-entry queue of classified characters.
    cmd_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{kind: classify(in_char), ch: in_char};
        end
    end

endmodule

`default_nettype wire

@@ src/clasm_back.sv @@
`default_nettype none

module clasm_back
    import clasm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SIZE_W-1:0] line_size,
    input  wire logic              cmd_valid,
    input  wire cmd_t              cmd,
    output logic                   cmd_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [STAT_W-1:0]      status,
    output logic [CHAR_W-1:0]      line_char,
    output logic [IDX_W-1:0]       line_length,
    output logic                   last
);

    logic [CHAR_W-1:0] line_mem [LINE_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  drain_reg, drain_next;
    logic              quote_reg, quote_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg, res_status;
    logic [CHAR_W-1:0] char_reg, res_char;
    logic [IDX_W-1:0]  len_reg, res_len;
    logic              last_reg, res_last;

    logic              load;
    logic              out_free;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [SIZE_W-1:0] size_eff;
    logic              store_full;
    logic              quote_tog;

    assign out_free   = !out_valid_reg || !out_stall;
    assign size_eff   = (line_size > SIZE_W'(LINE_DEPTH)) ? SIZE_W'(LINE_DEPTH) : line_size;
    assign store_full = !(({1'b0, fill_reg} + SIZE_W'(1)) < size_eff);
    assign quote_tog  = quote_reg ^ (cmd.kind == CK_QUOTE);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        drain_next = drain_reg;
        quote_next = quote_reg;
        cmd_pop    = 1'b0;
        load       = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = fill_reg - IDX_W'(1);
        wr_en      = 1'b0;
        res_status = STAT_INCOMPLETE;
        res_char   = '0;
        res_len    = '0;
        res_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    load    = 1'b1;
                    unique case (cmd.kind)
                        CK_EOL:
                        begin
                            fill_next  = '0;
                            quote_next = 1'b0;
                        end
                        CK_BS:
                        begin
                            if (fill_reg != '0)
                            begin
                                // The removed character is read back to undo its parity.
                                fill_next  = fill_reg - IDX_W'(1);
                                rd_en      = 1'b1;
                                rd_addr    = fill_reg - IDX_W'(1);
                                state_next = S_BSCHK;
                            end
                        end
                        default:
                        begin
                            if (store_full)
                            begin
                                quote_next = quote_tog;
                                res_status = STAT_FULL;
                            end
                            else if (cmd.kind == CK_SEMI && !quote_tog)
                            begin
                                if (fill_reg == '0)
                                begin
                                    res_status = STAT_DONE;
                                    quote_next = 1'b0;
                                end
                                else
                                begin
                                    load       = 1'b0;
                                    rd_en      = 1'b1;
                                    rd_addr    = '0;
                                    drain_next = '0;
                                    state_next = S_DRAIN;
                                end
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                fill_next  = fill_reg + IDX_W'(1);
                                quote_next = quote_tog;
                            end
                        end
                    endcase
                end
            end
            S_BSCHK:
            begin
                if (rd_data_reg == CH_QUOTE)
                begin
                    quote_next = !quote_reg;
                end
                state_next = S_IDLE;
            end
            S_DRAIN:
            begin
                res_status = STAT_DONE;
                res_char   = rd_data_reg;
                res_len    = fill_reg;
                res_last   = ((drain_reg + IDX_W'(1)) == fill_reg);
                if (out_free)
                begin
                    load = 1'b1;
                    if (res_last)
                    begin
                        fill_next  = '0;
                        quote_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        drain_next = drain_reg + IDX_W'(1);
                        rd_en      = 1'b1;
                        rd_addr    = drain_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            drain_reg     <= '0;
            quote_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drain_reg <= drain_next;
            quote_reg <= quote_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= res_status;
            char_reg   <= res_char;
            len_reg    <= res_len;
            last_reg   <= res_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[fill_reg] <= cmd.ch;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign line_char   = char_reg;
    assign line_length = len_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

@@ src/command_line_assembler.sv @@
// Channel   Handshake               Payload
// input     in_valid / in_stall     in_char
// output    out_valid / out_stall   status, line_char, line_length, last
// config    line_size_we            line_size_data
//
// An ordinary character, CR or LF is handled by the back end in S_IDLE alone; a
// backspace that removes a character also passes through S_BSCHK, since the removed byte is
// read back from the line store to undo its quote parity.
// A completing semicolon on a non-empty line is drained in S_DRAIN: the single read
// port of the line store delivers one character per cycle while the output is not stalled.
// Reset clears the line length, the quote parity and the queues; the line
// store itself is not cleared, as only written entries are ever read.
// Either side may stall at any time; the two-entry queue takes up to two items
// while the back end drains a line or waits on a stalled output.
`default_nettype none

module command_line_assembler
    import clasm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              line_size_we,
    input  wire logic [SIZE_W-1:0] line_size_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CHAR_W-1:0] in_char,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [STAT_W-1:0]      status,
    output logic [CHAR_W-1:0]      line_char,
    output logic [IDX_W-1:0]       line_length,
    output logic                   last
);

    // The usable store size. Values above the store depth behave as the
    // full depth, and values below two leave the store always full; that
    // clamp is applied in the back end.
    logic [SIZE_W-1:0] line_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_size_reg <= SIZE_W'(LINE_DEPTH);
        end
        else if (line_size_we)
        begin
            line_size_reg <= line_size_data;
        end
    end

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // The front end classifies each character and queues it.
    clasm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // The back end owns the line store, the fill index and the quote
    // parity, and produces every result through its output register.
    clasm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_size   (line_size_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .line_char   (line_char),
        .line_length (line_length),
        .last        (last)
    );

    // The back end only takes a character the queue actually holds.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("character taken from an empty queue");

    // Only a completed line spreads over several results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (status == STAT_DONE))
        else $error("non-final result outside a completed line");

    // Results other than line characters carry no character and no length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_DONE) |-> (line_length == '0 && line_char == '0))
        else $error("stray payload on a result that is not a line character");

    // A line drains without gaps once its first character is out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("gap inside a line drain");

endmodule

`default_nettype wire
